// File: rtl/itf_pkg.sv
// Shared types and constants for the impedance Tustin filter.
package itf_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned AccW   = 100;
    localparam int unsigned ProdW  = 66;
    localparam int unsigned DivW   = 31;
    localparam int unsigned DenW   = 57;
    localparam int unsigned CoefW  = 58;

    // configuration register indexes
    localparam logic [1:0] REG_MASS      = 2'd0;
    localparam logic [1:0] REG_DAMPING   = 2'd1;
    localparam logic [1:0] REG_STIFFNESS = 2'd2;
    localparam logic [1:0] REG_PERIOD    = 2'd3;

    localparam logic [DataW-1:0] MASS_RST   = 32'd65536;
    localparam logic [DataW-1:0] PERIOD_RST = 32'd201327;
    localparam logic [DataW-1:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] POS_MIN    = 32'h8000_0000;

    typedef enum logic [3:0] {
        MS_TSTS,
        MS_TSDAMP,
        MS_T2LO_K,
        MS_T2HI_K,
        MS_T2LO_F,
        MS_T2HI_F,
        MS_B1LO_X1,
        MS_B1HI_X1,
        MS_B2LO_X2,
        MS_B2HI_X2
    } msel_t;

    typedef enum logic [2:0] {
        AC_NONE,
        AC_SET,
        AC_ADD0,
        AC_ADD32,
        AC_SAR24
    } acc_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_T2,
        ST_MUL_TB,
        ST_MUL_KLO,
        ST_MUL_KHI,
        ST_ACC_KHI,
        ST_COEF,
        ST_MUL_FHI,
        ST_ACC_FHI,
        ST_SHIFT,
        ST_MUL_B1HI,
        ST_MUL_B2LO,
        ST_MUL_B2HI,
        ST_ACC_B2HI,
        ST_PREP,
        ST_SATCHK,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        msel_t   msel;
        acc_op_t acc_op;
        logic    cap_t2;
        logic    cap_tb;
        logic    coef;
        logic    prep;
        logic    satchk;
        logic    div_step;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic early;     // zero denominator or saturated quotient
        logic out_free;  // output register can take a result
    } status_t;

endpackage

// File: rtl/itf_ctrl.sv
// Sequencer for the filter datapath: multiply steps, accumulate, divide.
module itf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  itf_pkg::status_t status,
    output itf_pkg::cmd_t   cmd
);

    itf_pkg::state_t state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itf_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.msel     = itf_pkg::MS_TSTS;
        cmd.acc_op   = itf_pkg::AC_NONE;
        case (state_reg)
            itf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = itf_pkg::ST_MUL_T2;
                end
            end
            itf_pkg::ST_MUL_T2:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_TSTS;
                state_next = itf_pkg::ST_MUL_TB;
            end
            itf_pkg::ST_MUL_TB:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_TSDAMP;
                cmd.cap_t2 = 1'b1;
                state_next = itf_pkg::ST_MUL_KLO;
            end
            itf_pkg::ST_MUL_KLO:
            begin
                cmd.cap_tb = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_T2LO_K;
                state_next = itf_pkg::ST_MUL_KHI;
            end
            itf_pkg::ST_MUL_KHI:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_T2HI_K;
                cmd.acc_op = itf_pkg::AC_SET;
                state_next = itf_pkg::ST_ACC_KHI;
            end
            itf_pkg::ST_ACC_KHI:
            begin
                cmd.acc_op = itf_pkg::AC_ADD32;
                state_next = itf_pkg::ST_COEF;
            end
            itf_pkg::ST_COEF:
            begin
                cmd.coef   = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_T2LO_F;
                state_next = itf_pkg::ST_MUL_FHI;
            end
            itf_pkg::ST_MUL_FHI:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_T2HI_F;
                cmd.acc_op = itf_pkg::AC_SET;
                state_next = itf_pkg::ST_ACC_FHI;
            end
            itf_pkg::ST_ACC_FHI:
            begin
                cmd.acc_op = itf_pkg::AC_ADD32;
                state_next = itf_pkg::ST_SHIFT;
            end
            itf_pkg::ST_SHIFT:
            begin
                cmd.acc_op = itf_pkg::AC_SAR24;
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_B1LO_X1;
                state_next = itf_pkg::ST_MUL_B1HI;
            end
            itf_pkg::ST_MUL_B1HI:
            begin
                cmd.acc_op = itf_pkg::AC_ADD0;
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_B1HI_X1;
                state_next = itf_pkg::ST_MUL_B2LO;
            end
            itf_pkg::ST_MUL_B2LO:
            begin
                cmd.acc_op = itf_pkg::AC_ADD32;
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_B2LO_X2;
                state_next = itf_pkg::ST_MUL_B2HI;
            end
            itf_pkg::ST_MUL_B2HI:
            begin
                cmd.acc_op = itf_pkg::AC_ADD0;
                cmd.mul_en = 1'b1;
                cmd.msel   = itf_pkg::MS_B2HI_X2;
                state_next = itf_pkg::ST_ACC_B2HI;
            end
            itf_pkg::ST_ACC_B2HI:
            begin
                cmd.acc_op = itf_pkg::AC_ADD32;
                state_next = itf_pkg::ST_PREP;
            end
            itf_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = itf_pkg::ST_SATCHK;
            end
            itf_pkg::ST_SATCHK:
            begin
                cmd.satchk = 1'b1;
                cnt_next   = 5'(itf_pkg::DivW - 1);
                state_next = itf_pkg::ST_DIV;
            end
            itf_pkg::ST_DIV:
            begin
                // skip the divide when the result is already settled
                if (status.early)
                begin
                    state_next = itf_pkg::ST_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_next = itf_pkg::ST_FIN;
                    end
                end
            end
            itf_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = itf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itf_pkg::ST_IDLE;
            end
        endcase
    end

    property p_finish_free;
        @(posedge clk) disable iff (!rst_n) cmd.finish |-> status.out_free;
    endproperty
    a_finish_free: assert property (p_finish_free) else $error("result over unread output");

    property p_load_idle;
        @(posedge clk) disable iff (!rst_n) cmd.load |=> !in_ready;
    endproperty
    a_load_idle: assert property (p_load_idle) else $error("input taken while busy");

    property p_one_event;
        @(posedge clk) disable iff (!rst_n) $onehot0({cmd.load, cmd.div_step, cmd.finish});
    endproperty
    a_one_event: assert property (p_one_event) else $error("overlapping commands");

endmodule

// File: rtl/itf_datapath.sv
// Filter datapath: config registers, history, shared multiplier, accumulator, divider.
module itf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  itf_pkg::cmd_t       cmd,
    output itf_pkg::status_t    status,
    input  logic [31:0]         force_in,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_data
);

    localparam int unsigned AW = itf_pkg::AccW;

    logic [31:0] mass_reg, damping_reg, stiffness_reg, period_reg;
    logic [31:0] pos1_reg, pos2_reg, frc1_reg, frc2_reg, f0_reg;
    logic [33:0] fmag_reg;
    logic        fneg_reg;
    logic [63:0] t2_reg;
    logic [47:0] tb_reg;
    logic [itf_pkg::ProdW-1:0] p_reg;
    itf_pkg::msel_t psel_reg;
    logic [AW-1:0] acc_reg;
    logic [itf_pkg::DenW-1:0]  den_reg;
    logic [itf_pkg::CoefW-1:0] b1mag_reg, b2mag_reg;
    logic        b1neg_reg, b2neg_reg;
    logic [AW-1:0] dvd_reg, dsh_reg;
    logic        nneg_reg, sat_reg, zero_reg;
    logic [itf_pkg::DivW-1:0] q_reg;
    logic        ovalid_reg;
    logic [31:0] odata_reg;

    // force sum and history magnitudes
    logic signed [34:0] fsum;
    logic [33:0] fsum_mag;
    logic [31:0] x1mag, x2mag;
    logic        x1neg, x2neg;

    assign fsum = 35'(signed'(force_in)) + (35'(signed'(frc1_reg)) <<< 1)
                  + 35'(signed'(frc2_reg));
    assign fsum_mag = fsum[34] ? 34'(-fsum) : fsum[33:0];
    assign x1neg = pos1_reg[31];
    assign x2neg = pos2_reg[31];
    assign x1mag = x1neg ? -pos1_reg : pos1_reg;
    assign x2mag = x2neg ? -pos2_reg : pos2_reg;

    // multiplier operand selection
    logic [31:0] mul_a;
    logic [33:0] mul_b;
    always_comb
    begin
        case (cmd.msel)
            itf_pkg::MS_TSTS:    begin mul_a = period_reg;    mul_b = 34'(period_reg);    end
            itf_pkg::MS_TSDAMP:  begin mul_a = period_reg;    mul_b = 34'(damping_reg);   end
            itf_pkg::MS_T2LO_K:  begin mul_a = t2_reg[31:0];  mul_b = 34'(stiffness_reg); end
            itf_pkg::MS_T2HI_K:  begin mul_a = t2_reg[63:32]; mul_b = 34'(stiffness_reg); end
            itf_pkg::MS_T2LO_F:  begin mul_a = t2_reg[31:0];  mul_b = fmag_reg;           end
            itf_pkg::MS_T2HI_F:  begin mul_a = t2_reg[63:32]; mul_b = fmag_reg;           end
            itf_pkg::MS_B1LO_X1: begin mul_a = x1mag; mul_b = 34'(b1mag_reg[31:0]);       end
            itf_pkg::MS_B1HI_X1: begin mul_a = x1mag; mul_b = 34'(b1mag_reg[57:32]);      end
            itf_pkg::MS_B2LO_X2: begin mul_a = x2mag; mul_b = 34'(b2mag_reg[31:0]);       end
            itf_pkg::MS_B2HI_X2: begin mul_a = x2mag; mul_b = 34'(b2mag_reg[57:32]);      end
            default:             begin mul_a = '0;            mul_b = '0;                 end
        endcase
    end

    // sign of the term held in the product register
    logic pneg;
    always_comb
    begin
        case (psel_reg)
            itf_pkg::MS_T2LO_F, itf_pkg::MS_T2HI_F:   pneg = fneg_reg;
            itf_pkg::MS_B1LO_X1, itf_pkg::MS_B1HI_X1: pneg = ~(b1neg_reg ^ x1neg);
            itf_pkg::MS_B2LO_X2, itf_pkg::MS_B2HI_X2: pneg = ~(b2neg_reg ^ x2neg);
            default:                                  pneg = 1'b0;
        endcase
    end

    // accumulator update
    logic [AW-1:0] addend, term, acc_next;
    always_comb
    begin
        addend = AW'(p_reg);
        if (cmd.acc_op == itf_pkg::AC_ADD32)
        begin
            addend = addend << 32;
        end
        term = pneg ? -addend : addend;
        case (cmd.acc_op)
            itf_pkg::AC_SET:   acc_next = term;
            itf_pkg::AC_ADD0,
            itf_pkg::AC_ADD32: acc_next = acc_reg + term;
            itf_pkg::AC_SAR24: acc_next = AW'($signed(acc_reg) >>> 24);
            default:           acc_next = acc_reg;
        endcase
    end

    // coefficients from T^2 k (accumulator), T b and mass
    logic [55:0] tk;
    logic [59:0] m4, m8, den_w, b1_w, b2_w;
    assign tk    = acc_reg[95:40];
    assign m4    = 60'(mass_reg) << 10;
    assign m8    = 60'(mass_reg) << 11;
    assign den_w = m4 + (60'(tb_reg) << 1) + 60'(tk);
    assign b1_w  = (60'(tk) << 1) - m8;
    assign b2_w  = m4 - (60'(tb_reg) << 1) + 60'(tk);

    // rounding and divide helpers
    logic [AW-1:0] nmag, den_top;
    logic          dge;
    logic [31:0]   qfull, x_val;
    assign nmag    = acc_reg[AW-1] ? -acc_reg : acc_reg;
    assign den_top = AW'(den_reg) << itf_pkg::DivW;
    assign dge     = dvd_reg >= dsh_reg;
    assign qfull   = {1'b0, q_reg};

    always_comb
    begin
        if (zero_reg)
        begin
            x_val = '0;
        end
        else if (sat_reg)
        begin
            x_val = nneg_reg ? itf_pkg::POS_MIN : itf_pkg::POS_MAX;
        end
        else
        begin
            x_val = nneg_reg ? -qfull : qfull;
        end
    end

    // configuration and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg      <= itf_pkg::MASS_RST;
            damping_reg   <= '0;
            stiffness_reg <= '0;
            period_reg    <= itf_pkg::PERIOD_RST;
            pos1_reg      <= '0;
            pos2_reg      <= '0;
            frc1_reg      <= '0;
            frc2_reg      <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    itf_pkg::REG_MASS:      mass_reg      <= cfg_data;
                    itf_pkg::REG_DAMPING:   damping_reg   <= cfg_data;
                    itf_pkg::REG_STIFFNESS: stiffness_reg <= cfg_data;
                    itf_pkg::REG_PERIOD:    period_reg    <= cfg_data;
                    default:                mass_reg      <= mass_reg;
                endcase
            end
            if (cmd.finish)
            begin
                pos2_reg   <= pos1_reg;
                pos1_reg   <= x_val;
                frc2_reg   <= frc1_reg;
                frc1_reg   <= f0_reg;
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f0_reg   <= force_in;
            fmag_reg <= fsum_mag;
            fneg_reg <= fsum[34];
        end
        if (cmd.mul_en)
        begin
            p_reg    <= 66'(mul_a) * 66'(mul_b);
            psel_reg <= cmd.msel;
        end
        if (cmd.cap_t2)
        begin
            t2_reg <= p_reg[63:0];
        end
        if (cmd.cap_tb)
        begin
            tb_reg <= p_reg[63:16];
        end
        acc_reg <= acc_next;
        if (cmd.coef)
        begin
            den_reg   <= den_w[itf_pkg::DenW-1:0];
            b1neg_reg <= b1_w[59];
            b1mag_reg <= b1_w[59] ? 58'(-b1_w) : b1_w[57:0];
            b2neg_reg <= b2_w[59];
            b2mag_reg <= b2_w[59] ? 58'(-b2_w) : b2_w[57:0];
        end
        if (cmd.prep)
        begin
            nneg_reg <= acc_reg[AW-1];
            dvd_reg  <= nmag + AW'(den_reg >> 1);
            dsh_reg  <= AW'(den_reg) << (itf_pkg::DivW - 1);
            q_reg    <= '0;
        end
        if (cmd.satchk)
        begin
            zero_reg <= den_reg == '0;
            sat_reg  <= dvd_reg >= den_top;
        end
        if (cmd.div_step)
        begin
            if (dge)
            begin
                dvd_reg <= dvd_reg - dsh_reg;
            end
            q_reg   <= {q_reg[itf_pkg::DivW-2:0], dge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.finish)
        begin
            odata_reg <= x_val;
        end
    end

    assign status.early    = zero_reg | sat_reg;
    assign status.out_free = ~ovalid_reg | out_ready;
    assign out_valid       = ovalid_reg;
    assign out_data        = odata_reg;

    property p_finish_valid;
        @(posedge clk) disable iff (!rst_n) cmd.finish |=> ovalid_reg;
    endproperty
    a_finish_valid: assert property (p_finish_valid) else $error("result not posted");

    property p_div_not_early;
        @(posedge clk) disable iff (!rst_n) cmd.div_step |-> !status.early;
    endproperty
    a_div_not_early: assert property (p_div_not_early) else $error("divide after early exit");

    property p_cfg_quiet;
        @(posedge clk) disable iff (!rst_n) cmd.div_step |=> $stable(den_reg);
    endproperty
    a_cfg_quiet: assert property (p_cfg_quiet) else $error("divisor moved mid divide");

endmodule

// File: rtl/impedance_tustin_filter.sv
// Top level of the impedance Tustin filter: sequencer plus datapath.
//
//  channel | direction | payload                      | transfer when
//  s_*     | in        | tdata[31:0] force_sample     | s_tvalid & s_tready
//  m_*     | out       | tdata[31:0] position_out     | m_tvalid & m_tready
//  cfg_*   | in        | cfg_index, cfg_data          | cfg_valid & cfg_ready
//
// One sample runs through the multiply and accumulate steps and then 31 divide steps;
// a new input transfer is taken only after the last result enters the output register.
// The steps are set by the single shared 32x34 multiplier and the one-bit-per-cycle restoring
// divider; a saturated or zero-denominator result skips the divide.
// Reset clears the history and loads the default coefficients.
// A result waits in the output register; the next sample is taken meanwhile and
// only its final step waits for that register to drain.
module impedance_tustin_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] force_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] position_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    itf_pkg::cmd_t    cmd;
    itf_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    itf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic
    itf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .force_in  (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
